/* sv/srp_pkg.sv */
package srp_pkg;

    // field widths
    localparam int COORD_BITS  = 12;
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int DISP_W      = 12;
    localparam int MAXD_W      = 11;
    localparam int GREY_W      = 8;
    localparam int PIX_FRAC    = 8;
    localparam int SUBPIX_BITS = 4;
    localparam int OUT_W       = 32;
    localparam int DEPTH_W     = 31;

    // datapath widths
    localparam int MAG_W      = (COORD_BITS + PIX_FRAC > CFG_W) ? COORD_BITS + PIX_FRAC : CFG_W;
    localparam int AX_W       = MAG_W + CFG_W;
    localparam int AZ_W       = 2 * CFG_W;
    localparam int NY_W       = AX_W + CFG_W;
    localparam int NUM_W      = NY_W - SUBPIX_BITS;
    localparam int DEN_W      = MAXD_W + CFG_W;
    localparam int QUO_W      = 32;
    localparam int DIV_STAGES = QUO_W + 1;

    // register reset values
    localparam logic [CFG_W-1:0]  FOCAL_RST    = CFG_W'(256);
    localparam logic [CFG_W-1:0]  CENTER_RST   = '0;
    localparam logic [CFG_W-1:0]  BASELINE_RST = '0;
    localparam logic [MAXD_W-1:0] MAXD_RST     = MAXD_W'(1536);

    // configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_BASELINE = 3'd4,
        CFG_MAX_DISP = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_BITS-1:0]    pixel_col;
        logic [COORD_BITS-1:0]    pixel_row;
        logic signed [DISP_W-1:0] disparity_raw;
        logic [GREY_W-1:0]        grey_level;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic [DEPTH_W-1:0]      point_z;
        logic [GREY_W-1:0]       point_grey;
    } t_out;

endpackage

/* sv/srp_div.sv */
// pipelined restoring divider, one quotient bit per stage
module srp_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [srp_pkg::NUM_W-1:0]     i_num,
    input  logic [srp_pkg::DEN_W-1:0]     i_den,
    output logic [srp_pkg::QUO_W-1:0]     o_quo,
    output logic                          o_ovf
);

    localparam int QW = srp_pkg::QUO_W;
    localparam int DW = srp_pkg::DEN_W;
    localparam int NW = srp_pkg::NUM_W;

    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic          r_ovf [0:QW];

    // entry stage: a quotient of 2^32 or more sets the overflow flag, upper bits seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= (i_num >> QW) >= NW'(i_den);
            r_rem[0] <= DW'(i_num >> QW);
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
        end
    end

    // one trial subtract per stage
    for (genvar g = 1; g <= QW; g++) begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {r_rem[g-1], r_low[g-1][QW-1]};
        assign diff  = trial - {1'b0, r_den[g-1]};
        assign ge    = trial >= {1'b0, r_den[g-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_low[g] <= {r_low[g-1][QW-2:0], 1'b0};
                r_quo[g] <= {r_quo[g-1][QW-2:0], ge};
                r_den[g] <= r_den[g-1];
                r_ovf[g] <= r_ovf[g-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

/* sv/stereo_disparity_reproject.sv */
// channel  | handshake            | payload          | beat
// ---------+----------------------+------------------+-------------------------------
// pixel in | i_valid / o_stall    | i_data  (t_in)   | i_valid & !o_stall
// point out| o_valid / i_stall    | o_data  (t_out)  | o_valid & !i_stall
// config   | i_cfg_wr_en          | i_cfg_index/data | i_cfg_wr_en, no wait
//
// one pixel per cycle while the output queue is not full; each result passes through
// five arithmetic stages, a 33 stage bit-per-stage divider and one output stage
// pixels with disparity outside (0, max_disparity) travel as bubbles, no result
// synchronous active-low reset clears valid bits and output queue, and loads the config registers' reset values
// a two entry output queue absorbs downstream stall; the pipe freezes only
// when the queue is full, and o_stall comes straight from the queue count
module stereo_disparity_reproject (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  srp_pkg::t_in                     i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output srp_pkg::t_out                    o_data,
    input  logic                             i_cfg_wr_en,
    input  logic [srp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [srp_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int CB  = srp_pkg::COORD_BITS;
    localparam int CW  = srp_pkg::CFG_W;
    localparam int MW  = srp_pkg::MAG_W;
    localparam int XW  = srp_pkg::AX_W;
    localparam int ZW  = srp_pkg::AZ_W;
    localparam int YW  = srp_pkg::NY_W;
    localparam int NW  = srp_pkg::NUM_W;
    localparam int DW  = srp_pkg::DEN_W;
    localparam int QW  = srp_pkg::QUO_W;
    localparam int DDW = srp_pkg::MAXD_W;
    localparam int GW  = srp_pkg::GREY_W;
    localparam int OW  = srp_pkg::OUT_W;
    localparam int LW  = srp_pkg::DEPTH_W;
    localparam int NS  = srp_pkg::DIV_STAGES;

    typedef struct packed {
        logic          valid;
        logic          neg_x;
        logic          neg_y;
        logic [GW-1:0] grey;
    } t_side;

    // configuration registers
    logic [CW-1:0]  r_focal_x, r_focal_y, r_center_x, r_center_y, r_baseline;
    logic [DDW-1:0] r_max_disp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= srp_pkg::FOCAL_RST;
            r_focal_y  <= srp_pkg::FOCAL_RST;
            r_center_x <= srp_pkg::CENTER_RST;
            r_center_y <= srp_pkg::CENTER_RST;
            r_baseline <= srp_pkg::BASELINE_RST;
            r_max_disp <= srp_pkg::MAXD_RST;
        end else if (i_cfg_wr_en) begin
            case (srp_pkg::t_cfg_idx'(i_cfg_index))
                srp_pkg::CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                srp_pkg::CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                srp_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                srp_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
                srp_pkg::CFG_BASELINE: r_baseline <= i_cfg_data;
                srp_pkg::CFG_MAX_DISP: r_max_disp <= i_cfg_data[DDW-1:0];
                default: ;
            endcase
        end
    end

    // pipe advance: frozen only while the output queue is full
    logic [1:0] r_cnt;
    logic       en;

    assign en      = (r_cnt != 2'd2);
    assign o_stall = !en;

    // stage 1: capture pixel, screen disparity
    logic           d_ok;
    logic           r1_valid;
    logic [CB-1:0]  r1_u, r1_v;
    logic [DDW-1:0] r1_d;
    logic [GW-1:0]  r1_grey;

    assign d_ok = !i_data.disparity_raw[srp_pkg::DISP_W-1]
               && (i_data.disparity_raw[DDW-1:0] != '0)
               && (i_data.disparity_raw[DDW-1:0] < r_max_disp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid && d_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_u    <= i_data.pixel_col;
            r1_v    <= i_data.pixel_row;
            r1_d    <= i_data.disparity_raw[DDW-1:0];
            r1_grey <= i_data.grey_level;
        end
    end

    // stage 2: offsets from the principal point, vertical divisor
    logic [MW:0]   sc_u, sc_v, dif_x, dif_y;
    logic [CW-1:0] fy_eff;
    logic          r2_valid, r2_neg_x, r2_neg_y;
    logic [MW-1:0] r2_mag_x, r2_mag_y;
    logic [DDW-1:0] r2_d;
    logic [DW-1:0] r2_dfy;
    logic [GW-1:0] r2_grey;

    assign sc_u   = (MW+1)'({r1_u, {srp_pkg::PIX_FRAC{1'b0}}});
    assign sc_v   = (MW+1)'({r1_v, {srp_pkg::PIX_FRAC{1'b0}}});
    assign dif_x  = (sc_u < (MW+1)'(r_center_x)) ? (MW+1)'(r_center_x) - sc_u
                                                 : sc_u - (MW+1)'(r_center_x);
    assign dif_y  = (sc_v < (MW+1)'(r_center_y)) ? (MW+1)'(r_center_y) - sc_v
                                                 : sc_v - (MW+1)'(r_center_y);
    assign fy_eff = (r_focal_y == '0) ? CW'(1) : r_focal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_neg_x <= sc_u < (MW+1)'(r_center_x);
            r2_neg_y <= sc_v < (MW+1)'(r_center_y);
            r2_mag_x <= dif_x[MW-1:0];
            r2_mag_y <= dif_y[MW-1:0];
            r2_d     <= r1_d;
            r2_dfy   <= DW'(r1_d) * DW'(fy_eff);
            r2_grey  <= r1_grey;
        end
    end

    // stage 3: scale by baseline
    logic          r3_valid, r3_neg_x, r3_neg_y;
    logic [XW-1:0] r3_ax, r3_ay;
    logic [ZW-1:0] r3_az;
    logic [DDW-1:0] r3_d;
    logic [DW-1:0] r3_dfy;
    logic [GW-1:0] r3_grey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ax    <= XW'(r2_mag_x) * XW'(r_baseline);
            r3_ay    <= XW'(r2_mag_y) * XW'(r_baseline);
            r3_az    <= ZW'(r_focal_x) * ZW'(r_baseline);
            r3_neg_x <= r2_neg_x;
            r3_neg_y <= r2_neg_y;
            r3_d     <= r2_d;
            r3_dfy   <= r2_dfy;
            r3_grey  <= r2_grey;
        end
    end

    // stage 4: vertical numerator times focal_x, two partial products
    logic             r4_valid, r4_neg_x, r4_neg_y;
    logic [XW-1:0]    r4_ax;
    logic [ZW-1:0]    r4_az;
    logic [XW-1:0]    r4_py_hi;
    logic [2*CW-1:0]  r4_py_lo;
    logic [DDW-1:0]   r4_d;
    logic [DW-1:0]    r4_dfy;
    logic [GW-1:0]    r4_grey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_py_hi <= XW'(r3_ay[XW-1:CW]) * XW'(r_focal_x);
            r4_py_lo <= (2*CW)'(r3_ay[CW-1:0]) * (2*CW)'(r_focal_x);
            r4_ax    <= r3_ax;
            r4_az    <= r3_az;
            r4_neg_x <= r3_neg_x;
            r4_neg_y <= r3_neg_y;
            r4_d     <= r3_d;
            r4_dfy   <= r3_dfy;
            r4_grey  <= r3_grey;
        end
    end

    // stage 5: combine partial products
    logic          r5_valid, r5_neg_x, r5_neg_y;
    logic [XW-1:0] r5_ax;
    logic [ZW-1:0] r5_az;
    logic [YW-1:0] r5_ny;
    logic [DDW-1:0] r5_d;
    logic [DW-1:0] r5_dfy;
    logic [GW-1:0] r5_grey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ny    <= (YW'(r4_py_hi) << CW) + YW'(r4_py_lo);
            r5_ax    <= r4_ax;
            r5_az    <= r4_az;
            r5_neg_x <= r4_neg_x;
            r5_neg_y <= r4_neg_y;
            r5_d     <= r4_d;
            r5_dfy   <= r4_dfy;
            r5_grey  <= r4_grey;
        end
    end

    // dividers: sub-pixel scale folded into the numerator shift
    logic [QW-1:0] q_x, q_y, q_z;
    logic          ovf_x, ovf_y, ovf_z;

    srp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NW'(r5_ax >> srp_pkg::SUBPIX_BITS)),
        .i_den (DW'(r5_d)),
        .o_quo (q_x),
        .o_ovf (ovf_x)
    );

    srp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NW'(r5_ny >> srp_pkg::SUBPIX_BITS)),
        .i_den (r5_dfy),
        .o_quo (q_y),
        .o_ovf (ovf_y)
    );

    srp_div u_div_z (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (NW'(r5_az >> srp_pkg::SUBPIX_BITS)),
        .i_den (DW'(r5_d)),
        .o_quo (q_z),
        .o_ovf (ovf_z)
    );

    // sideband delay line matching the divider depth
    t_side r_sb [0:NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_sb[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_sb[0] <= '{valid: r5_valid, neg_x: r5_neg_x, neg_y: r5_neg_y, grey: r5_grey};
            for (int k = 1; k < NS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // saturate and apply sign
    t_side         sb_last;
    logic [OW-1:0] cap_x, cap_y, sat_x, sat_y;
    logic [LW-1:0] sat_z;
    srp_pkg::t_out n_out;

    assign sb_last = r_sb[NS-1];
    assign cap_x   = sb_last.neg_x ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    assign cap_y   = sb_last.neg_y ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    assign sat_x   = (ovf_x || q_x > cap_x) ? cap_x : q_x;
    assign sat_y   = (ovf_y || q_y > cap_y) ? cap_y : q_y;
    assign sat_z   = (ovf_z || q_z[QW-1]) ? {LW{1'b1}} : q_z[LW-1:0];

    always_comb begin
        n_out.point_x    = $signed(sb_last.neg_x ? (~sat_x + OW'(1)) : sat_x);
        n_out.point_y    = $signed(sb_last.neg_y ? (~sat_y + OW'(1)) : sat_y);
        n_out.point_z    = sat_z;
        n_out.point_grey = sb_last.grey;
    end

    // two entry output queue
    srp_pkg::t_out r_buf [0:1];
    logic          r_wr, r_rd;
    logic          push, pop;

    assign push    = en && sb_last.valid;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= n_out;
        end
    end

endmodule

/* bench/srp_point_checker.sv */
module srp_point_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pix_valid,
    input  logic                          i_pix_stall,
    input  srp_pkg::t_in                  i_pix_data,
    input  logic                          i_pt_valid,
    input  logic                          i_pt_stall,
    input  srp_pkg::t_out                 i_pt_data,
    input  logic                          i_cfg_wr_en,
    input  logic [srp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srp_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_points_pending
);
    import srp_pkg::*;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    // shadow copy of the camera registers
    logic [CFG_W-1:0]  cur_fx;
    logic [CFG_W-1:0]  cur_fy;
    logic [CFG_W-1:0]  cur_cx;
    logic [CFG_W-1:0]  cur_cy;
    logic [CFG_W-1:0]  cur_base;
    logic [MAXD_W-1:0] cur_dlim;

    // points still owed by the block, oldest first
    t_out due_points[$];

    initial begin
        o_fail_count     = 0;
        o_points_pending = 0;
    end

    // disparity strictly inside (0, limit)
    function automatic bit point_due(t_in px);
        logic [DISP_W-1:0] disp;
        disp = px.disparity_raw;
        return (disp != '0) && !disp[DISP_W-1] && (disp < cur_dlim);
    endfunction

    // floor(num*mult/den) clipped at cap
    function automatic logic [31:0] scaled_quot(logic [63:0] num, logic [63:0] mult,
                                                logic [63:0] den, logic [31:0] cap);
        logic [127:0] quot;
        quot = (128'(num) * 128'(mult)) / 128'(den);
        return (quot > 128'(cap)) ? cap : quot[31:0];
    endfunction

    // signed offset from the principal point, scaled by baseline and mult/den
    function automatic logic [31:0] lateral_coord(logic [63:0] pix, logic [63:0] ctr,
                                                  logic [63:0] mult, logic [63:0] den);
        logic [63:0] scaled;
        logic [63:0] mag;
        logic        neg;
        logic [31:0] quot;
        scaled = pix << PIX_FRAC;
        neg    = scaled < ctr;
        mag    = neg ? ctr - scaled : scaled - ctr;
        quot   = scaled_quot(mag * 64'(cur_base), mult, den, neg ? NEG_LIMIT : POS_LIMIT);
        return neg ? 32'd0 - quot : quot;
    endfunction

    function automatic t_out reproject_pixel(t_in px);
        logic [63:0] den;
        logic [63:0] fy_eff;
        t_out        pt;
        // a zero vertical focal acts as one
        fy_eff        = (cur_fy == '0) ? 64'd1 : 64'(cur_fy);
        den           = 64'(px.disparity_raw[DISP_W-1:0]) << SUBPIX_BITS;
        pt.point_x    = lateral_coord(64'(px.pixel_col), 64'(cur_cx), 64'd1, den);
        pt.point_y    = lateral_coord(64'(px.pixel_row), 64'(cur_cy), 64'(cur_fx),
                                      den * fy_eff);
        pt.point_z    = DEPTH_W'(scaled_quot(64'(cur_fx) * 64'(cur_base), 64'd1, den,
                                             POS_LIMIT));
        pt.point_grey = px.grey_level;
        return pt;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // register writes, output beats, then input beats
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            cur_fx   = FOCAL_RST;
            cur_fy   = FOCAL_RST;
            cur_cx   = CENTER_RST;
            cur_cy   = CENTER_RST;
            cur_base = BASELINE_RST;
            cur_dlim = MAXD_RST;
            due_points.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FOCAL_X:  cur_fx   = i_cfg_data;
                    CFG_FOCAL_Y:  cur_fy   = i_cfg_data;
                    CFG_CENTER_X: cur_cx   = i_cfg_data;
                    CFG_CENTER_Y: cur_cy   = i_cfg_data;
                    CFG_BASELINE: cur_base = i_cfg_data;
                    CFG_MAX_DISP: cur_dlim = i_cfg_data[MAXD_W-1:0];
                    default: ;
                endcase
            end
            if (i_pt_valid && !i_pt_stall) begin
                if (due_points.size() == 0) begin
                    $display("%0t: unexpected point, expected none, actual %h",
                             $time, i_pt_data);
                    o_fail_count++;
                end else begin
                    want = due_points.pop_front();
                    check_field("point_x", want.point_x, i_pt_data.point_x);
                    check_field("point_y", want.point_y, i_pt_data.point_y);
                    check_field("point_z", 32'(want.point_z), 32'(i_pt_data.point_z));
                    check_field("point_grey", 32'(want.point_grey),
                                32'(i_pt_data.point_grey));
                end
            end
            if (i_pix_valid && !i_pix_stall && point_due(i_pix_data))
                due_points.insert(due_points.size(), reproject_pixel(i_pix_data));
        end
        o_points_pending = due_points.size();
    end

endmodule

/* bench/tb_stereo_disparity_reproject.sv */
module tb_stereo_disparity_reproject;
    import srp_pkg::*;

    // indexes past the register file, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASE_POINTS  = 100;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    t_in                  pix_data  = '0;
    logic                 pt_valid;
    logic                 pt_stall  = 1'b0;
    t_out                 pt_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    int                   fail_count;
    int                   points_pending;

    // stimulus copy of the disparity limit, used only to shape pixels
    logic [MAXD_W-1:0]    stim_dlim    = MAXD_RST;
    bit                   sender_eager = 1'b0;

    always #10 clk = ~clk;

    stereo_disparity_reproject u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (pix_valid),
        .o_stall     (pix_stall),
        .i_data      (pix_data),
        .o_valid     (pt_valid),
        .i_stall     (pt_stall),
        .o_data      (pt_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    srp_point_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_pix_valid      (pix_valid),
        .i_pix_stall      (pix_stall),
        .i_pix_data       (pix_data),
        .i_pt_valid       (pt_valid),
        .i_pt_stall       (pt_stall),
        .i_pt_data        (pt_data),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_points_pending (points_pending)
    );

    // watchdog
    initial begin
        #8_000_000;
        $display("stereo_disparity_reproject test failed");
        $finish;
    end

    // downstream stall: short bursts, a few long ones, some calm stretches
    initial begin
        int pick;
        int len;
        @(posedge clk);
        forever begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                pt_stall <= 1'b0;
                len = $urandom_range(100, 300);
            end else if (pick < 12) begin
                pt_stall <= 1'b0;
                len = $urandom_range(1, 6);
            end else if (pick < 18) begin
                pt_stall <= 1'b1;
                len = $urandom_range(1, 4);
            end else begin
                pt_stall <= 1'b1;
                len = $urandom_range(10, 40);
            end
            repeat (len) @(posedge clk);
        end
    end

    function automatic t_in make_pixel(int col, int row, int disp, int grey);
        t_in px;
        px.pixel_col     = COORD_BITS'(col);
        px.pixel_row     = COORD_BITS'(row);
        px.disparity_raw = DISP_W'(disp);
        px.grey_level    = GREY_W'(grey);
        return px;
    endfunction

    function automatic int gap_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 0;
        if (pick == 1) return COORD_MAX;
        return $urandom_range(0, COORD_MAX);
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(int typ_lo, int typ_hi);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick == 2) return CFG_W'(1);
        if (pick < 5)  return CFG_W'($urandom());
        return CFG_W'($urandom_range(typ_lo, typ_hi));
    endfunction

    // disparity limit of at least two, junk in the bits above the register
    function automatic logic [CFG_W-1:0] pick_dlim_word();
        int pick;
        int lim;
        pick = $urandom_range(0, 9);
        if (pick == 0)      lim = 2047;
        else if (pick == 1) lim = 2;
        else if (pick < 5)  lim = 1536;
        else                lim = $urandom_range(2, 2047);
        return {(CFG_W - MAXD_W)'($urandom()), MAXD_W'(lim)};
    endfunction

    // mostly valid disparities, the rest zero, negative, at or past the limit, or random
    function automatic t_in rand_pixel(bit wellformed);
        int pick;
        int disp;
        pick = $urandom_range(0, 9);
        if (wellformed) begin
            if (pick < 2)
                disp = $urandom_range(1, (stim_dlim > 8) ? 8 : stim_dlim - 1);
            else
                disp = $urandom_range(1, stim_dlim - 1);
        end else begin
            case (pick)
                0: disp = 0;
                1: disp = -1;
                2: disp = stim_dlim;
                3: disp = -2048;
                4: disp = 2047;
                default: disp = $urandom_range(0, 4095);
            endcase
        end
        return make_pixel(pick_coord(), pick_coord(), disp, $urandom_range(0, 255));
    endfunction

    // one beat on the pixel channel, then maybe a gap
    task automatic send_pixel(t_in px);
        int gap;
        pix_valid <= 1'b1;
        pix_data  <= px;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        gap = sender_eager ? 0 : gap_cycles();
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0) @(posedge clk);
    endtask

    // let bubbles for dropped pixels leave the pipe too
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] fx, logic [CFG_W-1:0] fy,
                                logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                                logic [CFG_W-1:0] base, logic [CFG_W-1:0] dlim_word,
                                bit touch_spare);
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_BASELINE, base);
        write_reg(CFG_MAX_DISP, dlim_word);
        if (touch_spare) begin
            write_reg(CFG_UNUSED_A, CFG_W'($urandom()));
            write_reg(CFG_UNUSED_B, CFG_W'($urandom()));
        end
        cfg_wr_en <= 1'b0;
        stim_dlim = dlim_word[MAXD_W-1:0];
    endtask

    // random camera, then a stream of pixels with one full drain midway
    task automatic random_phase();
        int  points;
        int  items;
        bit  wellformed;
        bit  paused;
        program_regs(pick_reg(64 * 256, 2000 * 256), pick_reg(64 * 256, 2000 * 256),
                     pick_reg(0, COORD_MAX * 256), pick_reg(0, COORD_MAX * 256),
                     pick_reg(1000, 40000), pick_dlim_word(), $urandom_range(0, 1));
        points = 0;
        items  = 0;
        paused = 1'b0;
        while (points < PHASE_POINTS) begin
            if (items % 40 == 0)
                sender_eager = ($urandom_range(0, 2) == 0);
            if (!paused && points == PHASE_POINTS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            wellformed = (stim_dlim > 1) && ($urandom_range(0, 9) < 8);
            send_pixel(rand_pixel(wellformed));
            items++;
            if (wellformed) points++;
        end
        sender_eager = 1'b0;
        settle();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero baseline, limit of 96 pixels
        send_pixel(make_pixel(100, 200, 1, 8'h5A));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 1535, 255));
        send_pixel(make_pixel(7, 9, 1536, 0));
        settle();

        // typical camera, principal point hit exactly, every kind of bad disparity
        program_regs(20'd179328, 20'd179328, 20'd163840, 20'd92160, 20'd7864,
                     20'h00600, 1'b0);
        send_pixel(make_pixel(0, 0, 1, 0));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 1535, 255));
        send_pixel(make_pixel(640, 360, 16, 8'hAA));
        send_pixel(make_pixel(0, COORD_MAX, 2, 8'h55));
        send_pixel(make_pixel(1, 1, 0, 1));
        send_pixel(make_pixel(2, 2, -1, 2));
        send_pixel(make_pixel(3, 3, -2048, 3));
        send_pixel(make_pixel(4, 4, 1536, 4));
        send_pixel(make_pixel(5, 5, 2047, 5));
        settle();

        // full-scale registers, saturation on both sides
        program_regs('1, '1, '1, '0, '1, 20'h007FF, 1'b1);
        send_pixel(make_pixel(0, COORD_MAX, 1, 255));
        send_pixel(make_pixel(COORD_MAX, 0, 1, 0));
        send_pixel(make_pixel(0, COORD_MAX, 2046, 17));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 2047, 1));
        send_pixel(make_pixel(2048, 2048, 1000, 128));
        settle();

        // zero vertical focal, limit written with junk above bit 10
        program_regs(20'd76800, '0, '1, '1, '1, 20'hFFC40, 1'b0);
        send_pixel(make_pixel(0, 0, 1, 9));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 1087, 200));
        send_pixel(make_pixel(10, 10, 1088, 0));
        settle();

        // zero horizontal focal flattens depth and height
        program_regs('0, 20'd256, '0, '0, '1, 20'h00600, 1'b0);
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 1, 77));
        send_pixel(make_pixel(0, 0, 300, 66));
        settle();

        // limit of zero drops every pixel
        program_regs(20'd256, 20'd256, '0, '0, 20'd65536, 20'hFF800, 1'b1);
        send_pixel(make_pixel(1, 1, 1, 1));
        send_pixel(make_pixel(100, 100, 1000, 2));
        send_pixel(make_pixel(COORD_MAX, COORD_MAX, 2047, 255));
        settle();

        repeat (6) random_phase();

        if (fail_count == 0 && points_pending == 0) begin
            $display("stereo_disparity_reproject test passed");
        end else begin
            $display("stereo_disparity_reproject test failed");
        end
        $finish;
    end

endmodule
